FILE: rtl/core/crp_pkg.sv
package crp_pkg;

    localparam int DEF_CHUNK_SLOTS   = 1024;
    localparam int DEF_PENDING_DEPTH = 4;
    localparam int RESULT_CAP        = 20;

    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd1000;
    localparam logic [15:0] RST_PAYLOAD      = 16'd1024;
    localparam logic [15:0] RST_INIT_WINDOW  = 16'd2;
    localparam logic [15:0] RST_INIT_THRESH  = 16'd10;
    localparam logic [6:0]  RST_BURST_LIMIT  = 7'd20;

    typedef enum logic [2:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_PAYLOAD   = 3'd1,
        CFG_INIT_WIN  = 3'd2,
        CFG_INIT_THR  = 3'd3,
        CFG_BURST     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_SEGMENT = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_DATA    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CH_IDLE = 2'd0,
        CH_REQ  = 2'd1,
        CH_RECV = 2'd2,
        CH_LOST = 2'd3
    } chunk_st_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PREP,
        S_SCAN,
        S_FINISH,
        S_RECV_EV,
        S_EMIT
    } fsm_t;

endpackage

FILE: rtl/core/crp_div.sv
module crp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic        rem_nz
);

    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[15:0], q_reg[31]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign rem_nz   = (r_reg != '0);

endmodule

FILE: rtl/core/chunk_request_pipeline_aimd.sv
// Per item: an accepted segment is divided into chunks and queued, then the front segment
//   is scanned as on a tick; data marks one chunk received (when the segment retires, its
//   n entries are swept to idle). n is the front segment's chunk count; results are 1..20.
// Throughput: one item at a time; the next is taken once the last result is registered.
// Reset: synchronous, active low; after reset a clearing pass over all CHUNK_SLOTS entries
//   runs before the first item is taken. Configuration writes are taken at any time.
module chunk_request_pipeline_aimd
    import crp_pkg::*;
#(
    parameter int CHUNK_SLOTS   = DEF_CHUNK_SLOTS,
    parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_segment_bytes,
    input  logic [9:0]  s_chunk_index,
    input  logic        s_name_match,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_request_valid,
    output logic [9:0]  m_request_chunk,
    output logic        m_segment_done,
    output logic        m_rejected,
    output logic [15:0] m_window_now,
    output logic        m_last
);

    localparam int IW  = $clog2(CHUNK_SLOTS);
    localparam int CW  = $clog2(CHUNK_SLOTS + 1);
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);

    // configuration
    logic [15:0] timeout_reg, payload_reg, initw_reg, initthr_reg;
    logic [6:0]  burst_reg;

    // control state
    fsm_t            state_reg, state_next;
    logic [15:0]     window_reg, window_next;
    logic [15:0]     thr_reg, thr_next;
    logic [PAW-1:0]  head_reg, head_next;
    logic [PCW-1:0]  pcount_reg, pcount_next;
    logic [CW-1:0]   pend_mem [PENDING_DEPTH];
    logic            pend_we;
    logic [PAW-1:0]  pend_wa;
    logic [CW-1:0]   pend_wd;
    logic [CW-1:0]   recv_cnt_reg, recv_cnt_next;
    logic [31:0]     now_reg, now_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [4:0]      limit_reg, limit_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            lost_reg, lost_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            ev_vld_reg, ev_vld_next;
    logic [IW-1:0]   ev_idx_reg, ev_idx_next;
    logic [IW-1:0]   clr_idx_reg, clr_idx_next;
    logic [IW-1:0]   clr_last_reg, clr_last_next;
    logic            clr_emit_reg, clr_emit_next;
    logic            done_reg, done_next;
    logic            rej_reg, rej_next;
    logic [4:0]      em_idx_reg, em_idx_next;

    // result buffer
    logic [9:0]      reqbuf [RESULT_CAP];
    logic            buf_we;

    // chunk tables
    logic [1:0]      st_mem [CHUNK_SLOTS];
    logic [31:0]     rt_mem [CHUNK_SLOTS];
    logic [1:0]      st_rd_reg;
    logic [31:0]     rt_rd_reg;
    logic [IW-1:0]   rd_addr;
    logic            st_we, rt_we;
    logic [IW-1:0]   st_wa;
    logic [1:0]      st_wd;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        m_req_reg, m_req_next;
    logic [9:0]  m_chunk_reg, m_chunk_next;
    logic        m_done_reg, m_done_next;
    logic        m_rej_reg, m_rej_next;
    logic [15:0] m_win_reg, m_win_next;
    logic        m_last_reg, m_last_next;

    // divider
    logic        div_start, div_done, div_rnz;
    logic [31:0] div_q;
    logic [32:0] chunks;

    // helpers
    logic [CW-1:0]  n_head;
    logic [PAW-1:0] tail;
    logic [7:0]     tail_sum;
    logic [15:0]    lim_prod;
    logic [4:0]     lim10, limb;
    logic [16:0]    w_dbl;
    logic [15:0]    w_half, t_half;
    logic [CW-1:0]  recv_new;

    crp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_segment_bytes),
        .divisor  (payload_reg),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= RST_TIMEOUT_MS;
            payload_reg <= RST_PAYLOAD;
            initw_reg   <= RST_INIT_WINDOW;
            initthr_reg <= RST_INIT_THRESH;
            burst_reg   <= RST_BURST_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TIMEOUT:  timeout_reg <= cfg_data;
                CFG_PAYLOAD:  payload_reg <= cfg_data;
                CFG_INIT_WIN: initw_reg   <= cfg_data;
                CFG_INIT_THR: initthr_reg <= cfg_data;
                CFG_BURST:    burst_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign n_head   = pend_mem[head_reg];
    assign tail_sum = 8'(head_reg) + 8'(pcount_reg);
    assign tail     = (tail_sum >= 8'(PENDING_DEPTH)) ? PAW'(tail_sum - 8'(PENDING_DEPTH))
                                                       : PAW'(tail_sum);
    assign chunks   = {1'b0, div_q} + 33'(div_rnz);

    // ceil(window/10) via multiply by 205 >> 11 on an 8-bit sum, exact for window below 247
    assign lim_prod = 16'(8'(window_reg) + 8'd9) * 16'd205;
    assign lim10    = (window_reg >= 16'd191) ? 5'(RESULT_CAP) : lim_prod[15:11];
    assign limb     = (burst_reg > 7'(RESULT_CAP)) ? 5'(RESULT_CAP) : burst_reg[4:0];
    assign w_dbl    = {window_reg, 1'b0};
    assign w_half   = window_reg >> 1;
    assign t_half   = thr_reg >> 1;
    assign recv_new = recv_cnt_reg + CW'(st_rd_reg != CH_RECV);

    always_comb begin
        state_next    = state_reg;
        window_next   = window_reg;
        thr_next      = thr_reg;
        head_next     = head_reg;
        pcount_next   = pcount_reg;
        recv_cnt_next = recv_cnt_reg;
        now_next      = now_reg;
        n_next        = n_reg;
        limit_next    = limit_reg;
        cnt_next      = cnt_reg;
        lost_next     = lost_reg;
        rd_idx_next   = rd_idx_reg;
        ev_vld_next   = 1'b0;
        ev_idx_next   = ev_idx_reg;
        clr_idx_next  = clr_idx_reg;
        clr_last_next = clr_last_reg;
        clr_emit_next = clr_emit_reg;
        done_next     = done_reg;
        rej_next      = rej_reg;
        em_idx_next   = em_idx_reg;
        pend_we       = 1'b0;
        pend_wa       = tail;
        pend_wd       = CW'(chunks);
        buf_we        = 1'b0;
        st_we         = 1'b0;
        st_wa         = ev_idx_reg;
        st_wd         = CH_IDLE;
        rt_we         = 1'b0;
        rd_addr       = rd_idx_reg[IW-1:0];
        div_start     = 1'b0;
        s_ready       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_req_next    = m_req_reg;
        m_chunk_next  = m_chunk_reg;
        m_done_next   = m_done_reg;
        m_rej_next    = m_rej_reg;
        m_win_next    = m_win_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            S_CLEAR: begin
                st_we        = 1'b1;
                st_wa        = clr_idx_reg;
                st_wd        = CH_IDLE;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == clr_last_reg) begin
                    state_next = clr_emit_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                now_next  = s_now_ms;
                done_next = 1'b0;
                rej_next  = 1'b0;
                cnt_next  = '0;
                em_idx_next = '0;
                rd_addr   = IW'(s_chunk_index);
                if (s_valid) begin
                    case (s_command)
                        CMD_SEGMENT: begin
                            if (s_segment_bytes == '0 || payload_reg == '0 ||
                                pcount_reg >= PCW'(PENDING_DEPTH)) begin
                                rej_next   = 1'b1;
                                state_next = S_EMIT;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        CMD_TICK: begin
                            state_next = (pcount_reg != '0) ? S_PREP : S_EMIT;
                        end
                        CMD_DATA: begin
                            if (pcount_reg != '0 && s_name_match &&
                                32'(s_chunk_index) < 32'(n_head)) begin
                                ev_idx_next = IW'(s_chunk_index);
                                state_next  = S_RECV_EV;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (chunks > 33'(CHUNK_SLOTS)) begin
                        rej_next   = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        pend_we     = 1'b1;
                        pcount_next = pcount_reg + PCW'(1);
                        state_next  = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_next      = n_head;
                limit_next  = (lim10 < limb) ? lim10 : limb;
                cnt_next    = '0;
                lost_next   = 1'b0;
                rd_idx_next = '0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                // read entry i while deciding entry i-1
                if (rd_idx_reg < n_reg) begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (ev_vld_reg) begin
                    if (st_rd_reg == CH_IDLE || st_rd_reg == CH_LOST) begin
                        if (cnt_reg < limit_reg) begin
                            st_we    = 1'b1;
                            st_wd    = CH_REQ;
                            rt_we    = 1'b1;
                            buf_we   = 1'b1;
                            cnt_next = cnt_reg + 5'd1;
                        end
                    end else if (st_rd_reg == CH_REQ) begin
                        if ((now_reg - rt_rd_reg) > {16'd0, timeout_reg}) begin
                            st_we     = 1'b1;
                            st_wd     = CH_LOST;
                            lost_next = 1'b1;
                        end
                    end
                end
                if (rd_idx_reg >= n_reg && !ev_vld_reg) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (lost_reg) begin
                    window_next = (w_half < thr_reg) ? thr_reg : w_half;
                    thr_next    = (t_half < 16'd2) ? 16'd2 : t_half;
                end else if (cnt_reg != '0) begin
                    if (window_reg >= thr_reg) begin
                        window_next = (window_reg == 16'hFFFF) ? 16'hFFFF
                                                               : window_reg + 16'd1;
                    end else begin
                        window_next = w_dbl[16] ? 16'hFFFF : w_dbl[15:0];
                    end
                end
                state_next = S_EMIT;
            end
            S_RECV_EV: begin
                st_we = 1'b1;
                st_wd = CH_RECV;
                if (recv_new == n_head) begin
                    // segment complete: retire and sweep its entries back to idle
                    done_next     = 1'b1;
                    recv_cnt_next = '0;
                    head_next     = (head_reg == PAW'(PENDING_DEPTH - 1)) ? '0
                                                                         : head_reg + PAW'(1);
                    pcount_next   = pcount_reg - PCW'(1);
                    clr_idx_next  = '0;
                    clr_last_next = IW'(n_head - CW'(1));
                    clr_emit_next = 1'b1;
                    state_next    = S_CLEAR;
                end else begin
                    recv_cnt_next = recv_new;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_req_next   = (cnt_reg != '0);
                    m_chunk_next = (cnt_reg != '0) ? reqbuf[em_idx_reg] : '0;
                    m_done_next  = done_reg;
                    m_rej_next   = rej_reg;
                    m_win_next   = window_reg;
                    m_last_next  = (cnt_reg == '0) || (em_idx_reg == cnt_reg - 5'd1);
                    em_idx_next  = em_idx_reg + 5'd1;
                    if (m_last_next) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            window_reg   <= RST_INIT_WINDOW;
            thr_reg      <= RST_INIT_THRESH;
            head_reg     <= '0;
            pcount_reg   <= '0;
            recv_cnt_reg <= '0;
            ev_vld_reg   <= 1'b0;
            clr_idx_reg  <= '0;
            clr_last_reg <= IW'(CHUNK_SLOTS - 1);
            clr_emit_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            em_idx_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            thr_reg      <= thr_next;
            head_reg     <= head_next;
            pcount_reg   <= pcount_next;
            recv_cnt_reg <= recv_cnt_next;
            ev_vld_reg   <= ev_vld_next;
            clr_idx_reg  <= clr_idx_next;
            clr_last_reg <= clr_last_next;
            clr_emit_reg <= clr_emit_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            em_idx_reg   <= em_idx_next;
        end
        now_reg     <= now_next;
        n_reg       <= n_next;
        limit_reg   <= limit_next;
        lost_reg    <= lost_next;
        rd_idx_reg  <= rd_idx_next;
        ev_idx_reg  <= ev_idx_next;
        done_reg    <= done_next;
        rej_reg     <= rej_next;
        m_req_reg   <= m_req_next;
        m_chunk_reg <= m_chunk_next;
        m_done_reg  <= m_done_next;
        m_rej_reg   <= m_rej_next;
        m_win_reg   <= m_win_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_wa] <= pend_wd;
        end
        if (buf_we) begin
            reqbuf[cnt_reg] <= 10'(ev_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        if (rt_we) begin
            rt_mem[ev_idx_reg] <= now_reg;
        end
        st_rd_reg <= st_mem[rd_addr];
        rt_rd_reg <= rt_mem[rd_addr];
    end

    assign m_valid         = m_valid_reg;
    assign m_request_valid = m_req_reg;
    assign m_request_chunk = m_chunk_reg;
    assign m_segment_done  = m_done_reg;
    assign m_rejected      = m_rej_reg;
    assign m_window_now    = m_win_reg;
    assign m_last          = m_last_reg;

    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg <= limit_reg))
        else $error("request count exceeds pass limit");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg <= PCW'(PENDING_DEPTH))
        else $error("segment queue overfilled");

    a_recv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && pcount_reg != '0) |-> (recv_cnt_reg < n_head))
        else $error("complete segment not retired");

endmodule
